/* hw/rtl/ppp_pkg.sv */
// Shared constants, widths and types of the pinhole point projector.
package ppp_pkg;

    // Image size in pixels; the frame test bounds and the image center follow.
    localparam int IMAGE_COLS = 1920;
    localparam int IMAGE_ROWS = 1080;

    // Datapath widths
    localparam int FW = 16;           // field and register width
    localparam int DW17 = FW + 1;     // point minus camera offset
    localparam int PW = 2 * FW + 1;   // rotation product
    localparam int ZW = PW + 1;       // rotated coordinate scaled by 2^14
    localparam int NW = 51;           // focal times rotated coordinate
    localparam int MW = NW;           // rounded dividend magnitude
    localparam int DVW = ZW + 4;      // divisor, depth times 16
    localparam int QB = 17;           // quotient bits resolved by the divider
    localparam int CW = DVW + QB;     // trial subtraction width
    localparam int SW = QB + 2;       // signed pixel sum before saturation

    localparam int PRE_STAGES = 5;
    localparam int NUM_STAGES = PRE_STAGES + QB + 1;

    localparam logic [FW-1:0] ROT_COS_RST = 16'h0000;
    localparam logic [FW-1:0] ROT_SIN_RST = 16'hC000;
    localparam logic [FW-1:0] CAM_POS_RST = 16'h0000;
    localparam logic [FW-1:0] FOCAL_RST   = 16'd28197;

    typedef enum logic [2:0] {
        REG_ROT_COS   = 3'd0,
        REG_ROT_SIN   = 3'd1,
        REG_CAM_POS_X = 3'd2,
        REG_CAM_POS_Y = 3'd3,
        REG_CAM_POS_Z = 3'd4,
        REG_FOCAL_U   = 3'd5,
        REG_FOCAL_V   = 3'd6
    } cfg_reg_t;

    // Flags that ride along with a quotient through the divider
    typedef struct packed {
        logic neg;
        logic ovf;
        logic behind;
    } ppp_side_t;

endpackage

/* hw/rtl/pinhole_point_projector.sv */
// Top level of the pinhole point projector: config registers and the projection pipeline.
//
// Projects one world point (x, y, z in mm) per clock, while the output is not stalled,
// through a pinhole camera tilted about the X axis. From acceptance to a valid result an
// item passes one stage for the camera offset, one for the rotation products, one for the
// rotated sums, one for the focal multiplies, one to form the rounded dividend and its
// range check, seventeen stages of the pipelined restoring divider (one quotient bit
// each, the u and v dividers side by side), and the output stage that adds the image
// center, saturates and runs the frame test. Throughput is one item per clock while
// out_ready is high; every stage holds its own valid bit and stalls only when it is
// full and the stage after it cannot load, so bubbles collapse and a result waiting
// at the output blocks items upstream only once the stages behind it are full. A
// depth of zero or less flags behind_camera and forces u, v and in_frame to zero.
// Quotients that cannot fit are clamped so the pixel saturates. Configuration writes are
// always accepted (cfg_ready is tied high); write registers only while no item
// is in flight. An index of seven is ignored.
module pinhole_point_projector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [ppp_pkg::FW-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ppp_pkg::FW-1:0] world_x,
    input  logic signed [ppp_pkg::FW-1:0] world_y,
    input  logic signed [ppp_pkg::FW-1:0] world_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ppp_pkg::FW-1:0] pixel_u,
    output logic signed [ppp_pkg::FW-1:0] pixel_v,
    output logic                          in_frame,
    output logic                          behind_camera
);

    localparam int NS = ppp_pkg::NUM_STAGES;
    localparam int DV0 = ppp_pkg::PRE_STAGES;
    localparam int LAST = NS - 1;
    localparam logic signed [ppp_pkg::SW-1:0] CEN_U = ppp_pkg::SW'(ppp_pkg::IMAGE_COLS / 2);
    localparam logic signed [ppp_pkg::SW-1:0] CEN_V = ppp_pkg::SW'(ppp_pkg::IMAGE_ROWS / 2);
    localparam logic signed [ppp_pkg::FW-1:0] COLS = ppp_pkg::FW'(ppp_pkg::IMAGE_COLS);
    localparam logic signed [ppp_pkg::FW-1:0] ROWS = ppp_pkg::FW'(ppp_pkg::IMAGE_ROWS);
    localparam logic signed [ppp_pkg::SW-1:0] SAT_HI = ppp_pkg::SW'(32767);
    localparam logic signed [ppp_pkg::SW-1:0] SAT_LO = -ppp_pkg::SW'(32768);

    // ---------------- configuration registers ----------------
    logic [ppp_pkg::FW-1:0] rot_cos_reg, rot_sin_reg;
    logic [ppp_pkg::FW-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [ppp_pkg::FW-1:0] focal_u_reg, focal_v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_cos_reg <= ppp_pkg::ROT_COS_RST;
            rot_sin_reg <= ppp_pkg::ROT_SIN_RST;
            cam_x_reg   <= ppp_pkg::CAM_POS_RST;
            cam_y_reg   <= ppp_pkg::CAM_POS_RST;
            cam_z_reg   <= ppp_pkg::CAM_POS_RST;
            focal_u_reg <= ppp_pkg::FOCAL_RST;
            focal_v_reg <= ppp_pkg::FOCAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ppp_pkg::REG_ROT_COS:   rot_cos_reg <= cfg_data;
                ppp_pkg::REG_ROT_SIN:   rot_sin_reg <= cfg_data;
                ppp_pkg::REG_CAM_POS_X: cam_x_reg   <= cfg_data;
                ppp_pkg::REG_CAM_POS_Y: cam_y_reg   <= cfg_data;
                ppp_pkg::REG_CAM_POS_Z: cam_z_reg   <= cfg_data;
                ppp_pkg::REG_FOCAL_U:   focal_u_reg <= cfg_data;
                ppp_pkg::REG_FOCAL_V:   focal_v_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage valid chain ----------------
    // A stage loads when it is empty or its contents move on this cycle.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[LAST] = !vld_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[LAST];

    // ---------------- stage 0: offset by camera position ----------------
    logic signed [ppp_pkg::DW17-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [ppp_pkg::DW17-1:0] dx_next, dy_next, dz_next;

    assign dx_next = ppp_pkg::DW17'(world_x) - ppp_pkg::DW17'($signed(cam_x_reg));
    assign dy_next = ppp_pkg::DW17'(world_y) - ppp_pkg::DW17'($signed(cam_y_reg));
    assign dz_next = ppp_pkg::DW17'(world_z) - ppp_pkg::DW17'($signed(cam_z_reg));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
    end

    // ---------------- stage 1: rotation products ----------------
    logic signed [ppp_pkg::PW-1:0]   cy_reg, sz_reg, cz_reg, sy_reg;
    logic signed [ppp_pkg::PW-1:0]   cy_next, sz_next, cz_next, sy_next;
    logic signed [ppp_pkg::DW17-1:0] dx1_reg;

    assign cy_next = ppp_pkg::PW'($signed(rot_cos_reg)) * ppp_pkg::PW'(dy_reg);
    assign sz_next = ppp_pkg::PW'($signed(rot_sin_reg)) * ppp_pkg::PW'(dz_reg);
    assign cz_next = ppp_pkg::PW'($signed(rot_cos_reg)) * ppp_pkg::PW'(dz_reg);
    assign sy_next = ppp_pkg::PW'($signed(rot_sin_reg)) * ppp_pkg::PW'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cy_reg  <= cy_next;
            sz_reg  <= sz_next;
            cz_reg  <= cz_next;
            sy_reg  <= sy_next;
            dx1_reg <= dx_reg;
        end
    end

    // ---------------- stage 2: rotated Y and Z ----------------
    logic signed [ppp_pkg::ZW-1:0]   yq_reg, zq_reg, yq_next, zq_next;
    logic signed [ppp_pkg::DW17-1:0] dx2_reg;

    assign yq_next = ppp_pkg::ZW'(cy_reg) + ppp_pkg::ZW'(sz_reg);
    assign zq_next = ppp_pkg::ZW'(cz_reg) - ppp_pkg::ZW'(sy_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            yq_reg  <= yq_next;
            zq_reg  <= zq_next;
            dx2_reg <= dx1_reg;
        end
    end

    // ---------------- stage 3: focal multiplies, depth sign ----------------
    logic signed [ppp_pkg::NW-1:0] nu_reg, nv_reg, nu_next, nv_next;
    logic signed [ppp_pkg::ZW-1:0] zq3_reg;
    logic                          beh3_reg, beh3_next;
    logic signed [ppp_pkg::DW17+13:0] xq;

    assign xq = {dx2_reg, 14'd0};
    assign nu_next = ppp_pkg::NW'($signed({1'b0, focal_u_reg})) * ppp_pkg::NW'(xq);
    assign nv_next = ppp_pkg::NW'($signed({1'b0, focal_v_reg})) * ppp_pkg::NW'(yq_reg);
    assign beh3_next = (zq_reg <= 0);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            nu_reg   <= nu_next;
            nv_reg   <= nv_next;
            zq3_reg  <= zq_reg;
            beh3_reg <= beh3_next;
        end
    end

    // ---------------- stage 4: rounded dividends and range check ----------------
    // Add half the divisor to the magnitude so the quotient rounds half away
    // from zero; flag quotients that need more bits than the divider gives.
    logic [ppp_pkg::MW-1:0]  mu_reg, mv_reg, mu_next, mv_next;
    logic [ppp_pkg::DVW-1:0] dvs_reg, dvs_next;
    ppp_pkg::ppp_side_t      su_reg, sv_reg, su_next, sv_next;
    logic [ppp_pkg::MW-1:0]  mag_u, mag_v, half;
    logic [ppp_pkg::CW-1:0]  lim;

    assign mag_u    = nu_reg[ppp_pkg::NW-1] ? ppp_pkg::MW'(-nu_reg) : ppp_pkg::MW'(nu_reg);
    assign mag_v    = nv_reg[ppp_pkg::NW-1] ? ppp_pkg::MW'(-nv_reg) : ppp_pkg::MW'(nv_reg);
    assign half     = ppp_pkg::MW'({zq3_reg, 3'd0});
    assign mu_next  = mag_u + half;
    assign mv_next  = mag_v + half;
    assign dvs_next = {zq3_reg[ppp_pkg::ZW-1:0], 4'd0};
    assign lim      = {dvs_next, {ppp_pkg::QB{1'b0}}};

    always_comb
    begin
        su_next.neg    = nu_reg[ppp_pkg::NW-1];
        su_next.ovf    = ppp_pkg::CW'(mu_next) >= lim;
        su_next.behind = beh3_reg;
        sv_next.neg    = nv_reg[ppp_pkg::NW-1];
        sv_next.ovf    = ppp_pkg::CW'(mv_next) >= lim;
        sv_next.behind = beh3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            mu_reg  <= mu_next;
            mv_reg  <= mv_next;
            dvs_reg <= dvs_next;
            su_reg  <= su_next;
            sv_reg  <= sv_next;
        end
    end

    // ---------------- dividers ----------------
    logic [ppp_pkg::QB-1:0] qu, qv;
    ppp_pkg::ppp_side_t     squ, sqv;

    ppp_div u_div_u (
        .clk      (clk),
        .en       (en[DV0 + ppp_pkg::QB - 1 : DV0]),
        .dividend (mu_reg),
        .divisor  (dvs_reg),
        .side_in  (su_reg),
        .quotient (qu),
        .side_out (squ)
    );

    ppp_div u_div_v (
        .clk      (clk),
        .en       (en[DV0 + ppp_pkg::QB - 1 : DV0]),
        .dividend (mv_reg),
        .divisor  (dvs_reg),
        .side_in  (sv_reg),
        .quotient (qv),
        .side_out (sqv)
    );

    // ---------------- output stage: sign, center, saturate, frame test ----------------
    logic signed [ppp_pkg::FW-1:0] pu_reg, pv_reg, pu_next, pv_next;
    logic                          inf_reg, inf_next, beh_reg;
    logic signed [ppp_pkg::SW-1:0] mu_s, mv_s, su_s, sv_s;
    logic [ppp_pkg::QB-1:0]        qu_c, qv_c;

    assign qu_c = squ.ovf ? '1 : qu;
    assign qv_c = sqv.ovf ? '1 : qv;
    assign mu_s = $signed({2'b00, qu_c});
    assign mv_s = $signed({2'b00, qv_c});
    assign su_s = (squ.neg ? -mu_s : mu_s) + CEN_U;
    assign sv_s = (sqv.neg ? -mv_s : mv_s) + CEN_V;

    always_comb
    begin
        if (squ.behind)
        begin
            pu_next  = '0;
            pv_next  = '0;
            inf_next = 1'b0;
        end
        else
        begin
            if (su_s > SAT_HI)
                pu_next = SAT_HI[ppp_pkg::FW-1:0];
            else if (su_s < SAT_LO)
                pu_next = SAT_LO[ppp_pkg::FW-1:0];
            else
                pu_next = su_s[ppp_pkg::FW-1:0];
            if (sv_s > SAT_HI)
                pv_next = SAT_HI[ppp_pkg::FW-1:0];
            else if (sv_s < SAT_LO)
                pv_next = SAT_LO[ppp_pkg::FW-1:0];
            else
                pv_next = sv_s[ppp_pkg::FW-1:0];
            inf_next = (pu_next >= 0) && (pv_next >= 0)
                    && (pu_next <= COLS) && (pv_next <= ROWS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            pu_reg  <= pu_next;
            pv_reg  <= pv_next;
            inf_reg <= inf_next;
            beh_reg <= squ.behind;
        end
    end

    assign pixel_u       = pu_reg;
    assign pixel_v       = pv_reg;
    assign in_frame      = inf_reg;
    assign behind_camera = beh_reg;

endmodule

/* hw/rtl/ppp_div.sv */
// Pipelined restoring divider: one quotient bit per stage, stall per stage.
module ppp_div (
    input  logic                        clk,
    input  logic [ppp_pkg::QB-1:0]      en,
    input  logic [ppp_pkg::MW-1:0]      dividend,
    input  logic [ppp_pkg::DVW-1:0]     divisor,
    input  ppp_pkg::ppp_side_t          side_in,
    output logic [ppp_pkg::QB-1:0]      quotient,
    output ppp_pkg::ppp_side_t          side_out
);

    logic [ppp_pkg::MW-1:0]  rem_reg  [ppp_pkg::QB];
    logic [ppp_pkg::DVW-1:0] dvs_reg  [ppp_pkg::QB];
    logic [ppp_pkg::QB-1:0]  q_reg    [ppp_pkg::QB];
    ppp_pkg::ppp_side_t      side_reg [ppp_pkg::QB];

    for (genvar i = 0; i < ppp_pkg::QB; i++) begin : g_stage
        localparam int SH = ppp_pkg::QB - 1 - i;
        logic [ppp_pkg::MW-1:0]  rem_in;
        logic [ppp_pkg::DVW-1:0] dvs_in;
        logic [ppp_pkg::QB-1:0]  q_in;
        ppp_pkg::ppp_side_t      side_i;
        logic [ppp_pkg::CW-1:0]  trial;
        logic                    take;
        logic [ppp_pkg::MW-1:0]  rem_next;
        logic [ppp_pkg::QB-1:0]  q_next;

        if (i == 0) begin : g_first
            assign rem_in = dividend;
            assign dvs_in = divisor;
            assign q_in   = '0;
            assign side_i = side_in;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        // Subtract the shifted divisor; keep the remainder when it goes negative
        assign trial = {{(ppp_pkg::CW - ppp_pkg::MW){1'b0}}, rem_in}
                     - ({{ppp_pkg::QB{1'b0}}, dvs_in} << SH);
        assign take     = !trial[ppp_pkg::CW-1];
        assign rem_next = take ? trial[ppp_pkg::MW-1:0] : rem_in;
        assign q_next   = q_in | ({{(ppp_pkg::QB-1){1'b0}}, take} << SH);

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                rem_reg[i]  <= rem_next;
                dvs_reg[i]  <= dvs_in;
                q_reg[i]    <= q_next;
                side_reg[i] <= side_i;
            end
        end
    end

    assign quotient = q_reg[ppp_pkg::QB-1];
    assign side_out = side_reg[ppp_pkg::QB-1];

endmodule
